@@ rtl/core/mmor_pkg.sv @@
// Package for the moving mean unit with outlier rejection.
// Holds default parameters, register indexes, reset values and port widths.
// No dependencies.
`default_nettype none

package mmor_pkg;

  localparam int WINDOW_DEF      = 64;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int ALPHA_BITS      = 16;
  localparam int PADDR_W         = 3;
  localparam int PDATA_W         = 32;

  localparam logic REG_IDX_REJECT_ENABLE = 1'b0;
  localparam logic REG_IDX_ALPHA         = 1'b1;

  localparam logic                  REJECT_ENABLE_RST = 1'b1;
  localparam logic [ALPHA_BITS-1:0] ALPHA_RST         = 16'h8000;

endpackage

`default_nettype wire

@@ rtl/core/mmor_if.sv @@
// Stream interfaces for the moving mean unit: input samples and results.
// Depends on mmor_pkg for the default sample width.
`default_nettype none

interface mmor_in_if import mmor_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          restart;

  modport source (output valid, sample, restart, input ready);
  modport sink (input valid, sample, restart, output ready);
endinterface

interface mmor_out_if import mmor_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] kept_sample;
  logic signed [SAMPLE_BITS-1:0] mean;
  logic                          outlier;

  modport source (output valid, kept_sample, mean, outlier, input ready);
  modport sink (input valid, kept_sample, mean, outlier, output ready);
endinterface

`default_nettype wire

@@ rtl/core/moving_mean_outlier_reject_unit.sv @@
// Moving mean over a power-of-two window with outlier replacement.
// Each result is registered in the two-entry result buffer when its input is accepted.
// Throughput: one transaction per cycle while the result buffer is not full, set by the
// feedback of the previous mean through the threshold multiply, the sum update and the
// shift, with the delay memory doing one read and one write per cycle.
// Reset (synchronous) clears control state; the delay memory is not cleared.
`default_nettype none

module moving_mean_outlier_reject_unit import mmor_pkg::*; #(
  parameter int WINDOW      = WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  mmor_in_if.sink                 samples,
  mmor_out_if.source              results
);

  localparam int LOG_W  = $clog2(WINDOW);
  localparam int PTR_W  = (LOG_W < 1) ? 1 : LOG_W;
  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int SUM_W  = SAMPLE_BITS + LOG_W;
  localparam int PROD_W = ALPHA_BITS + SAMPLE_BITS;
  localparam int CMP_W  = SAMPLE_BITS + 1 + ALPHA_BITS;

  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW);
  localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(WINDOW - 1);
  localparam logic [PTR_W-1:0]  PTR_ONE   = PTR_W'(1);

  // Configuration registers.
  logic                  reject_enable;
  logic [ALPHA_BITS-1:0] alpha;
  logic                  cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      reject_enable <= REJECT_ENABLE_RST;
      alpha         <= ALPHA_RST;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_IDX_REJECT_ENABLE: reject_enable <= pwdata[0];
        REG_IDX_ALPHA:         alpha         <= pwdata[ALPHA_BITS-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_IDX_REJECT_ENABLE: prdata = {{(PDATA_W-1){1'b0}}, reject_enable};
      REG_IDX_ALPHA:         prdata = {{(PDATA_W-ALPHA_BITS){1'b0}}, alpha};
    endcase
  end

  // Filter state.
  logic                          started;
  logic [PTR_W-1:0]              wp;
  logic [FILL_W-1:0]             fill_count;
  logic signed [SAMPLE_BITS-1:0] first_value;
  logic signed [SUM_W-1:0]       window_sum;
  logic signed [SAMPLE_BITS-1:0] last_mean;

  logic signed [SAMPLE_BITS-1:0] delay_store [WINDOW];
  logic signed [SAMPLE_BITS-1:0] rd_data;

  logic                          in_fire;
  logic                          init;
  logic signed [SAMPLE_BITS-1:0] x;
  logic signed [SAMPLE_BITS-1:0] m;
  logic signed [SAMPLE_BITS:0]   dsub;
  logic [SAMPLE_BITS:0]          diff;
  logic [SAMPLE_BITS-1:0]        absm;
  logic [PROD_W-1:0]             rhs;
  logic [CMP_W-1:0]              lhs;
  logic                          kept_outlier;
  logic signed [SAMPLE_BITS-1:0] kept_sample;
  logic signed [SAMPLE_BITS-1:0] oldest;
  logic signed [SUM_W-1:0]       sum_base;
  logic signed [SUM_W-1:0]       window_sum_next;
  logic signed [SAMPLE_BITS-1:0] last_mean_next;
  logic [PTR_W-1:0]              wr_addr;
  logic [PTR_W-1:0]              wp_next;
  logic [FILL_W-1:0]             fill_count_next;
  logic [PTR_W-1:0]              rd_addr;

  assign in_fire = samples.valid && samples.ready;
  assign x       = samples.sample;
  assign init    = samples.restart || !started;
  assign m       = init ? x : last_mean;

  always_comb begin
    dsub = (SAMPLE_BITS+1)'(m) - (SAMPLE_BITS+1)'(x);
    diff = dsub[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-dsub) : (SAMPLE_BITS+1)'(dsub);
    absm = m[SAMPLE_BITS-1] ? SAMPLE_BITS'(-m) : SAMPLE_BITS'(m);
    rhs  = PROD_W'(alpha) * PROD_W'(absm);
    lhs  = {diff, {ALPHA_BITS{1'b0}}};
  end

  assign kept_outlier = reject_enable && (lhs > CMP_W'(rhs));
  assign kept_sample  = kept_outlier ? m : x;

  always_comb begin
    if (init) begin
      oldest = x;
    end else if (fill_count != FILL_FULL) begin
      oldest = first_value;
    end else begin
      oldest = rd_data;
    end
    sum_base        = init ? SUM_W'({x, {LOG_W{1'b0}}}) : window_sum;
    window_sum_next = sum_base + SUM_W'(kept_sample) - SUM_W'(oldest);
    last_mean_next  = window_sum_next[LOG_W +: SAMPLE_BITS];
    wr_addr         = init ? '0 : wp;
    wp_next         = (wr_addr == PTR_LAST) ? '0 : wr_addr + PTR_ONE;
    if (init) begin
      fill_count_next = FILL_W'(1);
    end else if (fill_count != FILL_FULL) begin
      fill_count_next = fill_count + FILL_W'(1);
    end else begin
      fill_count_next = fill_count;
    end
    rd_addr = in_fire ? wp_next : wp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started     <= 1'b0;
      wp          <= '0;
      fill_count  <= '0;
      first_value <= '0;
      window_sum  <= '0;
      last_mean   <= '0;
    end else if (in_fire) begin
      started     <= 1'b1;
      wp          <= wp_next;
      fill_count  <= fill_count_next;
      window_sum  <= window_sum_next;
      last_mean   <= last_mean_next;
      if (init) begin
        first_value <= x;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      delay_store[wr_addr] <= kept_sample;
    end
    rd_data <= delay_store[rd_addr];
  end

  // Two-entry result buffer so input transactions continue while a result waits.
  logic [1:0]                    out_count;
  logic signed [SAMPLE_BITS-1:0] slot_kept [2];
  logic signed [SAMPLE_BITS-1:0] slot_mean [2];
  logic                          slot_outl [2];
  logic                          out_fire;

  assign samples.ready       = (out_count != 2'd2);
  assign results.valid       = (out_count != 2'd0);
  assign results.kept_sample = slot_kept[0];
  assign results.mean        = slot_mean[0];
  assign results.outlier     = slot_outl[0];
  assign out_fire            = results.valid && results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_count <= 2'd0;
    end else begin
      out_count <= out_count + {1'b0, in_fire} - {1'b0, out_fire};
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && (out_count == 2'd0 || (out_count == 2'd1 && out_fire))) begin
      slot_kept[0] <= kept_sample;
      slot_mean[0] <= last_mean_next;
      slot_outl[0] <= kept_outlier;
    end else if (out_fire && out_count == 2'd2) begin
      slot_kept[0] <= slot_kept[1];
      slot_mean[0] <= slot_mean[1];
      slot_outl[0] <= slot_outl[1];
    end
    if (in_fire && out_count == 2'd1 && !out_fire) begin
      slot_kept[1] <= kept_sample;
      slot_mean[1] <= last_mean_next;
      slot_outl[1] <= kept_outlier;
    end
  end

  // A restart or the first transaction leaves exactly one sample in the window.
  a_restart_fill: assert property (@(posedge clk) disable iff (rst)
    in_fire && init |=> started && fill_count == FILL_W'(1) && wp == PTR_ONE)
    else $error("window not refilled after restart");

  // A replaced sample takes the previous mean.
  a_outlier_value: assert property (@(posedge clk) disable iff (rst)
    in_fire && kept_outlier |-> !init && kept_sample == last_mean)
    else $error("outlier not replaced by the previous mean");

  // With rejection off the sample passes unchanged.
  a_reject_off: assert property (@(posedge clk) disable iff (rst)
    in_fire && !reject_enable |-> !kept_outlier && kept_sample == x)
    else $error("sample altered with rejection disabled");

  // The result buffer never overflows and a push always yields a valid result.
  a_buffer: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> results.valid && out_count != 2'd3)
    else $error("result buffer lost a transaction");

endmodule

`default_nettype wire
